[sv/tsas_pkg.sv]
// Types, constants and divider step functions for the TDMA slot action scheduler.
package tsas_pkg;

  localparam int unsigned NumMemberRegs = 4;
  localparam int unsigned MaxMembers    = 4;
  localparam logic [7:0]  InvalidId     = 8'd255;
  localparam logic [15:0] BeaconMinLeft = 16'd2;
  localparam logic [15:0] RangeMinLeft  = 16'd5;

  // Slot-length divider: 4 quotient bits per stage, then frame divider: 8 bits per stage.
  localparam int unsigned P1Steps  = 4;
  localparam int unsigned P1Stages = 32 / P1Steps;
  localparam int unsigned P2Steps  = 8;
  localparam int unsigned P2Stages = 32 / P2Steps;
  localparam int unsigned DivStages = P1Stages + P2Stages;

  typedef enum logic [2:0] {
    CFG_LOCAL_ID     = 3'd0,
    CFG_SLOT_LENGTH  = 3'd1,
    CFG_MEMBER_TOTAL = 3'd2,
    CFG_MEMBER_A     = 3'd3,
    CFG_MEMBER_B     = 3'd4,
    CFG_MEMBER_C     = 3'd5,
    CFG_MEMBER_D     = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_LISTEN = 2'd0,
    ACT_BEACON = 2'd1,
    ACT_RANGE  = 2'd2
  } action_e;

  typedef struct packed {
    logic [31:0] now;   // original timestamp
    logic [31:0] dq;    // dividend bits shifting out, quotient bits shifting in
    logic [15:0] rem1;  // now mod slot length
    logic [3:0]  rem2;  // slot within frame
  } div_st_t;

  function automatic div_st_t f_pass1(div_st_t s, logic [15:0] len);
    logic [16:0] t;
    logic        ge;
    for (int i = 0; i < P1Steps; i++) begin
      t  = {s.rem1, s.dq[31]};
      ge = (t >= {1'b0, len});
      s.rem1 = ge ? 16'(t - {1'b0, len}) : t[15:0];
      s.dq   = {s.dq[30:0], ge};
    end
    return s;
  endfunction

  function automatic div_st_t f_pass2(div_st_t s, logic [3:0] slots);
    logic [4:0] t;
    logic       ge;
    for (int i = 0; i < P2Steps; i++) begin
      t  = {s.rem2, s.dq[31]};
      ge = (t >= {1'b0, slots});
      s.rem2 = ge ? 4'(t - {1'b0, slots}) : t[3:0];
      s.dq   = {s.dq[30:0], ge};
    end
    return s;
  endfunction

  function automatic logic [3:0] f_slots(logic [2:0] n);
    logic [3:0] r;
    unique case (n)
      3'd2:    r = 4'd3;
      3'd3:    r = 4'd6;
      3'd4:    r = 4'd10;
      default: r = 4'd1;
    endcase
    return r;
  endfunction

endpackage

[sv/tsas_req_if.sv]
// Request channel carrying one timestamp query.
interface tsas_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_time;

  modport source (output valid, output now_time, input ready);
  modport sink (input valid, input now_time, output ready);
endinterface

[sv/tsas_rsp_if.sv]
// Result channel carrying the slot action for one query.
interface tsas_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  peer;
  logic [7:0]  sender;
  logic [7:0]  receiver;
  logic [31:0] frame_number;
  logic [3:0]  slot_number;
  logic [31:0] slot_start;
  logic [31:0] slot_end;
  logic [15:0] time_left;
  logic        can_start;

  modport source (output valid, output action, output peer, output sender, output receiver,
                  output frame_number, output slot_number, output slot_start,
                  output slot_end, output time_left, output can_start, input ready);
  modport sink (input valid, input action, input peer, input sender, input receiver,
                input frame_number, input slot_number, input slot_start,
                input slot_end, input time_left, input can_start, output ready);
endinterface

[sv/tsas_divide.sv]
// Pipelined two-pass divider: timestamp by slot length, then slot by slots per frame.
module tsas_divide (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [31:0]          now_i,
  input  logic [15:0]          len_i,
  input  logic [3:0]           slots_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tsas_pkg::div_st_t    out_o
);
  import tsas_pkg::*;

  logic    [DivStages-1:0] v_q;
  logic    [DivStages:0]   rdy;
  div_st_t                 st_q  [DivStages];
  div_st_t                 src   [DivStages];
  div_st_t                 nxt   [DivStages];
  logic    [DivStages-1:0] v_in;

  // a stage moves when it is empty or its successor moves
  always_comb begin
    rdy[DivStages] = out_ready_i;
    for (int k = DivStages - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign v_in = {v_q[DivStages-2:0], in_valid_i};

  always_comb begin
    src[0] = '{now: now_i, dq: now_i, rem1: '0, rem2: '0};
    for (int k = 1; k < DivStages; k++) begin
      src[k] = st_q[k-1];
    end
    for (int k = 0; k < DivStages; k++) begin
      nxt[k] = (k < P1Stages) ? f_pass1(src[k], len_i) : f_pass2(src[k], slots_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < DivStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DivStages; k++) begin
      if (rdy[k]) begin
        st_q[k] <= nxt[k];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[DivStages-1];
  assign out_o       = st_q[DivStages-1];

  property p_rem1_below_len;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (out_o.rem1 < len_i);
  endproperty
  a_rem1_below_len: assert property (p_rem1_below_len)
    else $error("slot offset not below slot length");

  property p_rem2_below_slots;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (out_o.rem2 < slots_i);
  endproperty
  a_rem2_below_slots: assert property (p_rem2_below_slots)
    else $error("slot number not below slots per frame");

  property p_stall_holds_last;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_o));
  endproperty
  a_stall_holds_last: assert property (p_stall_holds_last)
    else $error("divider output lost while stalled");

endmodule

[sv/tdma_slot_action_scheduler_core.sv]
// Top level of the TDMA slot action scheduler: config registers, divider, decode, output.
// Takes one request per clock while the pipeline has room and returns one result per
// request, in order. 8 divider stages split the timestamp by the slot length (4 quotient
// bits each), 4 more split the slot index by the slots per frame (8 bits each), and one
// output register holds the decoded action. A stalled result side lets the pipeline keep
// filling until every stage holds a request. Configuration writes take effect at the next
// clock (the member sort one register later) and must happen with no request in flight.
module tdma_slot_action_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  tsas_req_if.sink    in_i,
  tsas_rsp_if.source  out_o
);
  import tsas_pkg::*;

  logic [7:0]  local_id_q;
  logic [15:0] slot_len_q;
  logic [2:0]  total_q;
  logic [7:0]  member_q  [NumMemberRegs];
  logic [7:0]  sorted_d  [NumMemberRegs];
  logic [7:0]  sorted_q  [NumMemberRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_id_q <= '0;
      slot_len_q <= 16'd1;
      total_q    <= '0;
      for (int i = 0; i < NumMemberRegs; i++) begin
        member_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOCAL_ID:     local_id_q <= cfg_wdata_i[7:0];
        CFG_SLOT_LENGTH:  slot_len_q <= (cfg_wdata_i == '0) ? 16'd1 : cfg_wdata_i;
        CFG_MEMBER_TOTAL: total_q    <= (cfg_wdata_i[2:0] > 3'(MaxMembers)) ?
                                        3'(MaxMembers) : cfg_wdata_i[2:0];
        CFG_MEMBER_A:     member_q[0] <= cfg_wdata_i[7:0];
        CFG_MEMBER_B:     member_q[1] <= cfg_wdata_i[7:0];
        CFG_MEMBER_C:     member_q[2] <= cfg_wdata_i[7:0];
        CFG_MEMBER_D:     member_q[3] <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // stable rank sort: position = smaller ids + equal ids that come first
  always_comb begin
    logic [2:0] pos;
    for (int i = 0; i < NumMemberRegs; i++) begin
      sorted_d[i] = '0;
    end
    for (int i = 0; i < NumMemberRegs; i++) begin
      pos = '0;
      for (int j = 0; j < NumMemberRegs; j++) begin
        if (j != i && 3'(j) < total_q &&
            (member_q[j] < member_q[i] || (j < i && member_q[j] == member_q[i]))) begin
          pos = pos + 3'd1;
        end
      end
      if (3'(i) < total_q) begin
        sorted_d[pos[1:0]] = member_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumMemberRegs; i++) begin
        sorted_q[i] <= '0;
      end
    end else begin
      sorted_q <= sorted_d;
    end
  end

  logic        div_valid;
  logic        div_ready;
  div_st_t     div_res;

  tsas_divide u_divide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .now_i       (in_i.now_time),
    .len_i       (slot_len_q),
    .slots_i     (f_slots(total_q)),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_o       (div_res)
  );

  // decode of one finished division
  action_e     act_d;
  logic [7:0]  peer_d, snd_d, rcv_d;
  logic [31:0] start_d, end_d;
  logic [15:0] left_d;
  logic        can_d;

  always_comb begin
    logic [3:0] ord;
    logic [3:0] seen;
    act_d   = ACT_LISTEN;
    peer_d  = InvalidId;
    snd_d   = InvalidId;
    rcv_d   = InvalidId;
    start_d = div_res.now - {16'd0, div_res.rem1};
    end_d   = start_d + {16'd0, slot_len_q};
    left_d  = slot_len_q - div_res.rem1;
    can_d   = 1'b1;
    ord     = div_res.rem2 - {1'b0, total_q};
    seen    = '0;
    if ({1'b0, div_res.rem2} < {2'd0, total_q}) begin
      snd_d = sorted_q[div_res.rem2[1:0]];
      if (snd_d == local_id_q) begin
        act_d = ACT_BEACON;
      end
    end else begin
      for (int i = 0; i < NumMemberRegs; i++) begin
        for (int j = i + 1; j < NumMemberRegs; j++) begin
          if (3'(j) < total_q) begin
            if (seen == ord) begin
              snd_d = sorted_q[i];
              rcv_d = sorted_q[j];
            end
            seen = seen + 4'd1;
          end
        end
      end
      if (local_id_q == snd_d) begin
        act_d  = ACT_RANGE;
        peer_d = rcv_d;
      end else if (local_id_q == rcv_d) begin
        peer_d = snd_d;
      end
    end
    unique case (act_d)
      ACT_BEACON: can_d = (left_d >= BeaconMinLeft);
      ACT_RANGE:  can_d = (left_d >= RangeMinLeft);
      default:    can_d = 1'b1;
    endcase
  end

  logic        out_v_q;
  action_e     act_q;
  logic [7:0]  peer_q, snd_q, rcv_q;
  logic [31:0] frame_q, start_q, end_q;
  logic [3:0]  slot_q;
  logic [15:0] left_q;
  logic        can_q;
  logic        no_members;

  assign div_ready  = !out_v_q || out_o.ready;
  assign no_members = (total_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (div_ready) begin
      out_v_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ready) begin
      act_q   <= no_members ? ACT_LISTEN : act_d;
      peer_q  <= no_members ? InvalidId : peer_d;
      snd_q   <= no_members ? InvalidId : snd_d;
      rcv_q   <= no_members ? InvalidId : rcv_d;
      frame_q <= no_members ? '0 : div_res.dq;
      slot_q  <= no_members ? '0 : div_res.rem2;
      start_q <= no_members ? '0 : start_d;
      end_q   <= no_members ? '0 : end_d;
      left_q  <= no_members ? '0 : left_d;
      can_q   <= no_members ? 1'b1 : can_d;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.action       = act_q;
  assign out_o.peer         = peer_q;
  assign out_o.sender       = snd_q;
  assign out_o.receiver     = rcv_q;
  assign out_o.frame_number = frame_q;
  assign out_o.slot_number  = slot_q;
  assign out_o.slot_start   = start_q;
  assign out_o.slot_end     = end_q;
  assign out_o.time_left    = left_q;
  assign out_o.can_start    = can_q;

  property p_empty_listens;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_v_q && no_members) |-> (act_q == ACT_LISTEN && can_q && left_q == '0);
  endproperty
  a_empty_listens: assert property (p_empty_listens)
    else $error("request with no members did not listen");

  property p_active_is_local;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_v_q && (act_q == ACT_BEACON || act_q == ACT_RANGE)) |-> (snd_q == local_id_q);
  endproperty
  a_active_is_local: assert property (p_active_is_local)
    else $error("beacon or range issued for another node");

  property p_left_in_slot;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_v_q && !no_members) |-> (left_q != '0 && left_q <= slot_len_q);
  endproperty
  a_left_in_slot: assert property (p_left_in_slot)
    else $error("time left outside the slot");

  property p_end_after_start;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_v_q && !no_members) |-> (end_q - start_q == {16'd0, slot_len_q});
  endproperty
  a_end_after_start: assert property (p_end_after_start)
    else $error("slot end does not match slot length");

endmodule

[bench/tdma_slot_action_scheduler_core_tb.sv]
// Testbench for the TDMA slot action scheduler: directed table, random queries, scoreboard.
`timescale 1ns / 100ps
module tdma_slot_action_scheduler_core_tb;
  import tsas_pkg::*;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  peer;
    logic [7:0]  sender;
    logic [7:0]  receiver;
    logic [31:0] frame_number;
    logic [3:0]  slot_number;
    logic [31:0] slot_start;
    logic [31:0] slot_end;
    logic [15:0] time_left;
    logic        can_start;
  } slot_act_t;

  typedef struct {
    logic [31:0] now;
    bit          typed;
    slot_act_t   want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  tsas_req_if req_if ();
  tsas_rsp_if rsp_if ();

  tdma_slot_action_scheduler_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .in_i(req_if.sink), .out_o(rsp_if.source)
  );

  // shadow registers
  logic [7:0]  sh_local;
  logic [15:0] sh_len;
  logic [2:0]  sh_total;
  logic [7:0]  sh_mem [4];

  slot_act_t   pending_acts [$];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  int unsigned sent_cnt;
  bit          no_idle;
  bit          hold_off;
  bit          stim_done;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic slot_act_t predict_slot(logic [31:0] now);
    slot_act_t   r;
    logic [7:0]  m [4];
    logic [7:0]  key;
    int unsigned n, slots, absl, ord, seen, j;
    bit          found;
    r = '0;
    r.action = ACT_LISTEN;
    r.peer = InvalidId;
    r.sender = InvalidId;
    r.receiver = InvalidId;
    r.can_start = 1'b1;
    n = sh_total;
    if (n == 0) return r;
    slots = n + n * (n - 1) / 2;
    for (int i = 0; i < 4; i++) m[i] = sh_mem[i];
    for (int i = 1; i < n; i++) begin
      key = m[i];
      j = i;
      while (j > 0 && m[j-1] > key) begin
        m[j] = m[j-1];
        j--;
      end
      m[j] = key;
    end
    absl = now / sh_len;
    r.frame_number = absl / slots;
    r.slot_number = 4'(absl % slots);
    r.slot_start = absl * sh_len;
    r.slot_end = r.slot_start + sh_len;
    r.time_left = 16'(r.slot_end - now);
    if (r.slot_number < n) begin
      r.sender = m[r.slot_number[1:0]];
      if (m[r.slot_number[1:0]] == sh_local) r.action = ACT_BEACON;
    end else begin
      ord = r.slot_number - n;
      seen = 0;
      found = 0;
      for (int i = 0; i < n && !found; i++) begin
        for (int k = i + 1; k < n && !found; k++) begin
          if (seen == ord) begin
            r.sender = m[i];
            r.receiver = m[k];
            found = 1;
          end
          seen++;
        end
      end
      if (sh_local == r.sender) begin
        r.action = ACT_RANGE;
        r.peer = r.receiver;
      end else if (sh_local == r.receiver) begin
        r.peer = r.sender;
      end
    end
    if (r.action == ACT_BEACON) r.can_start = r.time_left >= BeaconMinLeft;
    else if (r.action == ACT_RANGE) r.can_start = r.time_left >= RangeMinLeft;
    return r;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LOCAL_ID:     sh_local = val[7:0];
      CFG_SLOT_LENGTH:  sh_len = (val == 0) ? 16'd1 : val;
      CFG_MEMBER_TOTAL: sh_total = (val[2:0] > MaxMembers) ? 3'(MaxMembers) : val[2:0];
      CFG_MEMBER_A:     sh_mem[0] = val[7:0];
      CFG_MEMBER_B:     sh_mem[1] = val[7:0];
      CFG_MEMBER_C:     sh_mem[2] = val[7:0];
      CFG_MEMBER_D:     sh_mem[3] = val[7:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_query(logic [31:0] now, bit typed, slot_act_t want);
    while (!no_idle && $urandom_range(99) < 19) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.now_time <= now;
    pending_acts.push_back(typed ? want : predict_slot(now));
    sent_cnt++;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic drain;
    req_if.valid <= 1'b0;
    while (pending_acts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_time();
    case ($urandom_range(3))
      0: return $urandom_range(200);
      1: return 32'hFFFF_FFFF - $urandom_range(200);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      slot_act_t got, want;
      got = {rsp_if.action, rsp_if.peer, rsp_if.sender, rsp_if.receiver,
             rsp_if.frame_number, rsp_if.slot_number, rsp_if.slot_start,
             rsp_if.slot_end, rsp_if.time_left, rsp_if.can_start};
      if (pending_acts.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        fail_cnt++;
      end else begin
        want = pending_acts.pop_front();
        if (got !== want) begin
          $display("%0t mismatch expected %h actual %h", $time, want, got);
          fail_cnt++;
        end
      end
    end
  end

  // result side: random stalls plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= !hold_off && (no_idle || $urandom_range(99) >= 19);
    end
  end

  // hold-off lands in the middle of a random phase while requests keep coming
  initial begin
    int n_hold;
    hold_off = 0;
    wait (stim_done == 0 && sent_cnt > 600);
    hold_off = 1;
    n_hold = 0;
    while (n_hold < 60) begin
      @(posedge clk_i);
      n_hold++;
    end
    hold_off = 0;
  end

  dir_row_t dir_tab [$];

  initial begin
    slot_act_t zero_act;
    logic [7:0] ids [4];
    fail_cnt = 0;
    cycle_cnt = 0;
    sent_cnt = 0;
    no_idle = 0;
    stim_done = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_LOCAL_ID;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.now_time = '0;
    sh_local = 0;
    sh_len = 1;
    sh_total = 0;
    for (int i = 0; i < 4; i++) sh_mem[i] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no members after reset: listen, all numbers zero
    zero_act = '0;
    zero_act.peer = InvalidId;
    zero_act.sender = InvalidId;
    zero_act.receiver = InvalidId;
    zero_act.can_start = 1'b1;
    dir_tab.push_back('{32'd0, 1, zero_act});
    dir_tab.push_back('{32'hFFFF_FFFF, 1, zero_act});
    dir_tab.push_back('{32'h5555_AAAA, 1, zero_act});
    foreach (dir_tab[i]) send_query(dir_tab[i].now, dir_tab[i].typed, dir_tab[i].want);
    drain();

    // four members unordered with duplicate, local beacons and ranges
    write_reg(CFG_SLOT_LENGTH, 16'd0);
    write_reg(CFG_MEMBER_TOTAL, 16'd7);
    write_reg(CFG_MEMBER_A, 16'd9);
    write_reg(CFG_MEMBER_B, 16'd3);
    write_reg(CFG_MEMBER_C, 16'd255);
    write_reg(CFG_MEMBER_D, 16'd3);
    write_reg(CFG_LOCAL_ID, 16'd3);
    for (int t = 0; t < 12; t++) send_query(t, 0, zero_act);
    send_query(32'hFFFF_FFFF, 0, zero_act);
    drain();
    write_reg(CFG_SLOT_LENGTH, 16'hFFFF);
    write_reg(CFG_LOCAL_ID, 16'd255);
    send_query(32'hFFFF_FFFF, 0, zero_act);
    send_query(32'd65534, 0, zero_act);
    send_query(32'd65535 * 7 + 65533, 0, zero_act);
    send_query(32'h8000_0000, 0, zero_act);
    drain();
    write_reg(CFG_SLOT_LENGTH, 16'd6);
    write_reg(CFG_LOCAL_ID, 16'd9);
    for (int t = 0; t < 8; t++) send_query(6 * 9 + t, 0, zero_act);
    drain();

    // random phases with random configurations
    for (int ph = 0; ph < 16; ph++) begin
      no_idle = (ph == 5);
      for (int i = 0; i < 4; i++) begin
        ids[i] = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(5));
      end
      write_reg(CFG_MEMBER_A, {8'($urandom_range(255)), ids[0]});
      write_reg(CFG_MEMBER_B, {8'h0, ids[1]});
      write_reg(CFG_MEMBER_C, {8'hFF, ids[2]});
      write_reg(CFG_MEMBER_D, {8'h0, ids[3]});
      write_reg(CFG_MEMBER_TOTAL, 16'($urandom_range(7)));
      write_reg(CFG_LOCAL_ID, $urandom_range(1) ? {8'h0, ids[$urandom_range(3)]} : 16'($urandom));
      case ($urandom_range(3))
        0: write_reg(CFG_SLOT_LENGTH, 16'($urandom_range(8)));
        1: write_reg(CFG_SLOT_LENGTH, 16'(16'hFFFF - $urandom_range(3)));
        default: write_reg(CFG_SLOT_LENGTH, 16'($urandom));
      endcase
      for (int k = 0; k < 100; k++) send_query(rand_time(), 0, zero_act);
      drain();
    end
    stim_done = 1;
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[files.f]
sv/tsas_pkg.sv
sv/tsas_req_if.sv
sv/tsas_rsp_if.sv
sv/tsas_divide.sv
sv/tdma_slot_action_scheduler_core.sv
bench/tdma_slot_action_scheduler_core_tb.sv
